>>> hdl/mf5_pkg.sv
// shared constants, types and helpers for the 5x5 median filter
package mf5_pkg;

  // default parameter values
  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CHANNELS_DEF    = 4;

  // fixed geometry of the window
  localparam int WIN      = 5;
  localparam int WIN_AREA = 25;
  localparam int MID_RANK = 12;
  localparam int LINES    = 4;
  localparam int NCH_MAX  = 4;

  // port widths
  localparam int IO_BITS  = 16;
  localparam int CFG_BITS = 12;
  localparam int IDX_BITS = 3;
  localparam int COL_BITS = 11;
  localparam int ROW_BITS = 12;

  // position limits
  localparam logic [COL_BITS-1:0] COL_MAX = 11'd2047;
  localparam logic [ROW_BITS-1:0] ROW_MAX = 12'd4095;

  // register indexes
  localparam logic [IDX_BITS-1:0] REG_PADDED_WIDTH = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_OFFSET_W     = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_OFFSET_H     = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_OUT_WIDTH    = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_OUT_HEIGHT   = 3'd4;

  // register reset values
  localparam logic [11:0] PADDED_WIDTH_RST = 12'd2048;
  localparam logic [10:0] OFFSET_W_RST     = 11'd2;
  localparam logic [11:0] OFFSET_H_RST     = 12'd2;
  localparam logic [10:0] OUT_WIDTH_RST    = 11'd2044;
  localparam logic [11:0] OUT_HEIGHT_RST   = 12'd1;

  // output queue
  localparam int OUT_DEPTH  = 8;
  localparam int PIPE_ITEMS = 5;

  // per-request tag carried down the pipeline
  typedef struct packed {
    logic prod;
    logic rend;
    logic fend;
  } tag_t;

  // rank of one window sample from its precedence bits
  function automatic logic [4:0] count_ones25(input logic [WIN_AREA-1:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < WIN_AREA; i++) begin
      n = n + 5'(v[i]);
    end
    return n;
  endfunction

endpackage

>>> hdl/mf5_ram.sv
// generic single-port-write, single-port-read ram with registered read
module mf5_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/median_filter_5x5_rgba.sv
// 5x5 median filter over a padded multi-channel raster stream
//
// Input channel: one padded pixel per request (chan_0..chan_3, frame_start),
// taken when in_valid is high and in_stall is low. frame_start restarts the
// position counters at row 0, column 0.
// Output channel: one request per output centre (median_0..median_3,
// row_end, frame_end), taken when out_valid is high and out_stall is low.
// Configuration: cfg_write with cfg_index and cfg_data, written while idle.
// Throughput: one pixel per clock while in_stall is low. The line stores are
// one ram holding all four previous rows of a column, read and written back
// once per pixel; a write and a read of the same column in one cycle are
// forwarded. Pipeline order: ram read, window shift, compare matrix, rank
// count, output queue.
// The median network is a rank-count matrix per channel, fully pipelined.
// Stall: results wait in an 8-entry queue; in_stall rises once the queue
// holds more than 3 entries, so no request in flight is ever lost.
// Reset: counters, window, registers and queue are cleared at once; the
// line store ram is not cleared and no clearing pass is needed.
module median_filter_5x5_rgba
  import mf5_pkg::*;
#(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int CHANNELS    = CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [IO_BITS-1:0]  chan_0,
  input  logic [IO_BITS-1:0]  chan_1,
  input  logic [IO_BITS-1:0]  chan_2,
  input  logic [IO_BITS-1:0]  chan_3,
  input  logic                frame_start,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [IO_BITS-1:0]  median_0,
  output logic [IO_BITS-1:0]  median_1,
  output logic [IO_BITS-1:0]  median_2,
  output logic [IO_BITS-1:0]  median_3,
  output logic                row_end,
  output logic                frame_end
);

  localparam int SB  = SAMPLE_BITS;
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int MW  = LINES * CHANNELS * SB;
  localparam int QAW = $clog2(OUT_DEPTH);
  localparam int QCW = QAW + 1;
  localparam logic [QCW-1:0] ACCEPT_MAX = QCW'(OUT_DEPTH - PIPE_ITEMS);

  // configuration registers
  logic [11:0] padded_width;
  logic [10:0] offset_w;
  logic [11:0] offset_h;
  logic [10:0] out_width;
  logic [11:0] out_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      padded_width <= PADDED_WIDTH_RST;
      offset_w     <= OFFSET_W_RST;
      offset_h     <= OFFSET_H_RST;
      out_width    <= OUT_WIDTH_RST;
      out_height   <= OUT_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PADDED_WIDTH: padded_width <= cfg_data;
        REG_OFFSET_W:     offset_w     <= cfg_data[10:0];
        REG_OFFSET_H:     offset_h     <= cfg_data;
        REG_OUT_WIDTH:    out_width    <= cfg_data[10:0];
        REG_OUT_HEIGHT:   out_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input acceptance
  logic [QCW-1:0] q_count;
  logic           acc;

  assign in_stall = (q_count > ACCEPT_MAX);
  assign acc      = in_valid && !in_stall;

  // input samples cut to the sample width
  logic [IO_BITS-1:0] chan_in [NCH_MAX];
  logic [SB-1:0]      pix0    [CHANNELS];

  assign chan_in[0] = chan_0;
  assign chan_in[1] = chan_1;
  assign chan_in[2] = chan_2;
  assign chan_in[3] = chan_3;

  always_comb begin
    logic [IO_BITS+SB-1:0] ext;
    ext = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      ext      = {{SB{1'b0}}, chan_in[ch]};
      pix0[ch] = ext[SB-1:0];
    end
  end

  // position of the incoming pixel and output decision
  logic [COL_BITS-1:0] column_count;
  logic [ROW_BITS-1:0] row_count;
  logic [COL_BITS-1:0] cur_col;
  logic [ROW_BITS-1:0] cur_row;
  logic                wrap;
  logic [12:0]         row_min;
  logic [11:0]         col_min;
  logic [11:0]         dy;
  logic [10:0]         dx;
  logic [11:0]         dx_wide;
  logic                in_area;
  tag_t                tag0;
  logic [AW-1:0]       addr0;
  logic [COL_BITS+AW-1:0] addr_ext;

  always_comb begin
    cur_col  = frame_start ? '0 : column_count;
    cur_row  = frame_start ? '0 : row_count;
    wrap     = (12'(cur_col) + 12'd1 >= padded_width) || (cur_col == COL_MAX);
    row_min  = 13'(offset_h) + 13'd2;
    col_min  = 12'(offset_w) + 12'd2;
    in_area  = (13'(cur_row) >= row_min) && (12'(cur_col) >= col_min);
    dy       = 12'(13'(cur_row) - row_min);
    dx_wide  = 12'(cur_col) - col_min;
    dx       = dx_wide[10:0];
    tag0.prod = in_area && (dy < out_height) && (dx < out_width);
    tag0.rend = (12'(dx) + 12'd1 == 12'(out_width));
    tag0.fend = tag0.rend && (13'(dy) + 13'd1 == 13'(out_height));
    addr_ext = {{AW{1'b0}}, cur_col};
    addr0    = addr_ext[AW-1:0];
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (acc) begin
      if (wrap) begin
        column_count <= '0;
        row_count    <= (cur_row == ROW_MAX) ? ROW_MAX : cur_row + 12'd1;
      end else begin
        column_count <= cur_col + 11'd1;
        row_count    <= cur_row;
      end
    end
  end

  // stage 1: line store read
  logic          s1_v;
  tag_t          s1_tag;
  logic [AW-1:0] s1_addr;
  logic [SB-1:0] s1_pix [CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_tag  <= tag0;
      s1_addr <= addr0;
      s1_pix  <= pix0;
    end
  end

  logic [MW-1:0] ram_q;
  logic [MW-1:0] wr_data;
  logic [MW-1:0] fwd_data;
  logic          fwd_hit;
  logic [MW-1:0] line_rd;

  mf5_ram #(
    .WIDTH(MW),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk    (clk),
    .rd_en  (acc),
    .rd_addr(addr0),
    .rd_data(ram_q),
    .wr_en  (s1_v),
    .wr_addr(s1_addr),
    .wr_data(wr_data)
  );

  // forward a write that lands on the column read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (acc) begin
      fwd_hit <= s1_v && (s1_addr == addr0);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fwd_data <= wr_data;
    end
  end

  // column vector: four stored rows and the new pixel, rows shifted up
  logic [SB-1:0] colv [WIN][CHANNELS];

  always_comb begin
    line_rd = fwd_hit ? fwd_data : ram_q;
    wr_data = '0;
    for (int k = 0; k < LINES; k++) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        colv[k][ch] = line_rd[(k*CHANNELS+ch)*SB +: SB];
      end
    end
    for (int ch = 0; ch < CHANNELS; ch++) begin
      colv[LINES][ch] = s1_pix[ch];
    end
    for (int k = 0; k < LINES; k++) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        wr_data[(k*CHANNELS+ch)*SB +: SB] = colv[k+1][ch];
      end
    end
  end

  // stage 2: sliding window
  logic [SB-1:0] win [WIN][WIN][CHANNELS];
  tag_t          s2_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int y = 0; y < WIN; y++) begin
        for (int x = 0; x < WIN; x++) begin
          for (int ch = 0; ch < CHANNELS; ch++) begin
            win[y][x][ch] <= '0;
          end
        end
      end
      s2_tag <= '0;
    end else begin
      s2_tag <= s1_v ? s1_tag : '0;
      if (s1_v) begin
        for (int y = 0; y < WIN; y++) begin
          for (int x = 0; x < WIN - 1; x++) begin
            win[y][x] <= win[y][x+1];
          end
          win[y][WIN-1] <= colv[y];
        end
      end
    end
  end

  // stage 3: pairwise precedence matrix per channel
  logic [SB-1:0]       s3_val [CHANNELS][WIN_AREA];
  logic [WIN_AREA-1:0] s3_lt  [CHANNELS][WIN_AREA];
  tag_t                s3_tag;

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int i = 0; i < WIN_AREA; i++) begin
        s3_val[ch][i] <= win[i / WIN][i % WIN][ch];
        for (int j = 0; j < WIN_AREA; j++) begin
          s3_lt[ch][i][j] <= (win[j / WIN][j % WIN][ch] < win[i / WIN][i % WIN][ch]) ||
                             ((win[j / WIN][j % WIN][ch] == win[i / WIN][i % WIN][ch]) &&
                              (j < i));
        end
      end
    end
  end

  // stage 4: rank count, one-hot pick of the middle rank
  logic [SB-1:0]       s4_val [CHANNELS][WIN_AREA];
  logic [WIN_AREA-1:0] s4_sel [CHANNELS];
  tag_t                s4_tag;

  always_ff @(posedge clk) begin
    s4_val <= s3_val;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int i = 0; i < WIN_AREA; i++) begin
        s4_sel[ch][i] <= (count_ones25(s3_lt[ch][i]) == 5'(MID_RANK));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_tag <= '0;
      s4_tag <= '0;
    end else begin
      s3_tag <= s2_tag;
      s4_tag <= s3_tag;
    end
  end

  // median select
  logic [SB-1:0] med [CHANNELS];

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      med[ch] = '0;
      for (int i = 0; i < WIN_AREA; i++) begin
        med[ch] = med[ch] | (s4_val[ch][i] & {SB{s4_sel[ch][i]}});
      end
    end
  end

  // output queue
  logic [SB-1:0]  q_med  [OUT_DEPTH][CHANNELS];
  logic           q_rend [OUT_DEPTH];
  logic           q_fend [OUT_DEPTH];
  logic [QAW-1:0] q_wptr;
  logic [QAW-1:0] q_rptr;
  logic           q_push;
  logic           q_pop;

  assign q_push = s4_tag.prod;
  assign q_pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_med[q_wptr]  <= med;
      q_rend[q_wptr] <= s4_tag.rend;
      q_fend[q_wptr] <= s4_tag.fend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wptr  <= '0;
      q_rptr  <= '0;
      q_count <= '0;
    end else begin
      if (q_push) begin
        q_wptr <= q_wptr + 1'b1;
      end
      if (q_pop) begin
        q_rptr <= q_rptr + 1'b1;
      end
      case ({q_push, q_pop})
        2'b10:   q_count <= q_count + 1'b1;
        2'b01:   q_count <= q_count - 1'b1;
        default: q_count <= q_count;
      endcase
    end
  end

  // output ports
  logic [IO_BITS-1:0] med_out [NCH_MAX];

  always_comb begin
    logic [SB+IO_BITS-1:0] ext;
    ext = '0;
    for (int ch = 0; ch < NCH_MAX; ch++) begin
      med_out[ch] = '0;
    end
    for (int ch = 0; ch < CHANNELS; ch++) begin
      ext         = {{IO_BITS{1'b0}}, q_med[q_rptr][ch]};
      med_out[ch] = ext[IO_BITS-1:0];
    end
  end

  assign out_valid = (q_count != '0);
  assign median_0  = med_out[0];
  assign median_1  = med_out[1];
  assign median_2  = med_out[2];
  assign median_3  = med_out[3];
  assign row_end   = q_rend[q_rptr];
  assign frame_end = q_fend[q_rptr];

endmodule

>>> hdl/mf5_checker.sv
// port-level checks for the median filter, bound to the top level
module mf5_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] median_0,
  input logic        row_end,
  input logic        frame_end
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its median_0 and row_end
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(median_0) && $stable(row_end))
    else $error("stalled result changed");

  // the last result of a frame also closes its row
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> row_end)
    else $error("frame end without row end");

  // reset empties the output queue
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind median_filter_5x5_rgba mf5_checker u_mf5_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .median_0 (median_0),
  .row_end  (row_end),
  .frame_end(frame_end)
);
